### rtl/core/cascaded_position_velocity_pid_defines.svh
`ifndef CASCADED_POSITION_VELOCITY_PID_DEFINES_SVH
`define CASCADED_POSITION_VELOCITY_PID_DEFINES_SVH

// Checked property with the reset masking it.
`define CPV_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpvpid assertion failed");

// Checked property that also holds while reset is applied.
`define CPV_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("cpvpid assertion failed during or after reset");

`endif

### rtl/core/cpvpid_pkg.sv
`default_nettype none

package cpvpid_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VEL_KP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_KI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_KD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_KP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_KI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_KD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_DIV = 3'd6;

    localparam logic signed [15:0] RST_VEL_KP = 16'sd5;
    localparam logic signed [15:0] RST_VEL_KI = 16'sd1;
    localparam logic signed [15:0] RST_VEL_KD = 16'sd1;
    localparam logic signed [15:0] RST_POS_KP = 16'sd1;
    localparam logic signed [15:0] RST_POS_KI = 16'sd1;
    localparam logic signed [15:0] RST_POS_KD = 16'sd0;
    localparam logic [7:0]         RST_POS_DIV = 8'd4;

    localparam logic signed [31:0] CMP_LIMIT = 32'sd1000;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_MOVE = 1'b1
    } t_command;

    typedef struct packed {
        logic               command;
        logic signed [15:0] encoder_count;
        logic               counting_down;
        logic signed [31:0] move_target;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        forward_compare;
        logic [15:0]        reverse_compare;
        logic               moving;
        logic [15:0]        move_ticks;
        logic signed [31:0] position;
    } t_out_item;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MOVE,
        DP_TICK,
        DP_ERR,
        DP_DIFF,
        DP_MUL_P,
        DP_MUL_I,
        DP_MUL_D,
        DP_ACC,
        DP_UPD,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel_vel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_move;
        logic div_hit;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_ERR,
        S_DIFF,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_UPD,
        S_POST
    } t_state;

    function automatic logic signed [47:0] sx32(input logic signed [31:0] v);
        return {{16{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v[47:31] == {17{1'b0}} || v[47:31] == {17{1'b1}}) begin
            r = v[31:0];
        end else if (v[47]) begin
            r = {1'b1, {31{1'b0}}};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/cascaded_position_velocity_pid.sv
`default_nettype none

// Cascaded position and velocity controller with incremental PID loops.
// The input channel (i_valid / o_ready / i_item) takes one transaction per
// control tick or move command; the output channel (o_valid / i_ready /
// o_result) returns exactly one result per input transaction, in order.
// The user must write gains and the position loop divider through i_cfg_we,
// i_cfg_index and i_cfg_data only while the block is idle; it does not check.
// One shared 16x32 multiplier serves each PID pass through the ERR, DIFF,
// MUL_P, MUL_I, MUL_D, ACC and UPD states. A move or a tick that runs only
// the velocity loop makes one pass; a tick that also runs the position loop
// makes a position pass, then a velocity pass. The input is ready again in
// the cycle after the result is loaded. The result sits in an output
// register: a stalled receiver holds it, the next item is still accepted,
// and only its own result waits until the register frees up. Synchronous
// reset restores the default gains, clears all loop state and drops o_valid.
module cascaded_position_velocity_pid (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire cpvpid_pkg::t_in_item                i_item,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output cpvpid_pkg::t_out_item                    o_result,
    input  wire logic                                i_cfg_we,
    input  wire logic [cpvpid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cpvpid_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cpvpid_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cpvpid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    cpvpid_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

### rtl/core/cpvpid_datapath.sv
`default_nettype none

module cpvpid_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire cpvpid_pkg::t_dp_cmd                 i_cmd,
    output cpvpid_pkg::t_dp_stat                     o_stat,
    input  wire cpvpid_pkg::t_in_item                i_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [cpvpid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cpvpid_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output cpvpid_pkg::t_out_item                    o_result
);
    import cpvpid_pkg::*;

    // Gains and divider.
    logic signed [15:0] r_vel_kp, r_vel_ki, r_vel_kd;
    logic signed [15:0] r_pos_kp, r_pos_ki, r_pos_kd;
    logic [7:0]         r_pos_div;

    // Controller state.
    logic signed [31:0] r_pos_target, r_pos_actual, r_pos_err_last, r_pos_err_prev;
    logic signed [31:0] r_pos_err_now, r_pos_out, r_vel_target;
    logic signed [31:0] r_vel_err_last, r_vel_err_prev;
    logic [15:0]        r_fwd_cmp, r_rev_cmp;
    logic               r_move_flag;
    logic [15:0]        r_tick_cnt;
    logic [7:0]         r_div_cnt;

    // Working registers of the shared PID unit.
    t_in_item           r_item;
    logic signed [31:0] r_err, r_d1, r_d2;
    logic signed [47:0] r_prod, r_sum;
    t_out_item          r_result;

    logic signed [15:0] w_kp, w_ki, w_kd, w_mul_a;
    logic signed [31:0] w_e1, w_e2, w_target, w_actual, w_mul_b, w_out, w_neg;
    logic signed [47:0] w_prod, w_enc48, w_pos_step;
    logic signed [16:0] w_enc_ext;
    logic [16:0]        w_enc_mag;

    always_comb begin
        w_kp     = i_cmd.sel_vel ? r_vel_kp : r_pos_kp;
        w_ki     = i_cmd.sel_vel ? r_vel_ki : r_pos_ki;
        w_kd     = i_cmd.sel_vel ? r_vel_kd : r_pos_kd;
        w_e1     = i_cmd.sel_vel ? r_vel_err_last : r_pos_err_last;
        w_e2     = i_cmd.sel_vel ? r_vel_err_prev : r_pos_err_prev;
        w_target = i_cmd.sel_vel ? r_vel_target : r_pos_target;
        w_actual = i_cmd.sel_vel ? {{16{r_item.encoder_count[15]}}, r_item.encoder_count}
                                 : r_pos_actual;
        case (i_cmd.op)
            DP_MUL_I: begin
                w_mul_a = w_ki;
                w_mul_b = r_err;
            end
            DP_MUL_D: begin
                w_mul_a = w_kd;
                w_mul_b = r_d2;
            end
            default: begin
                w_mul_a = w_kp;
                w_mul_b = r_d1;
            end
        endcase
        w_prod     = w_mul_a * w_mul_b;
        w_enc48    = {{32{r_item.encoder_count[15]}}, r_item.encoder_count};
        w_pos_step = r_item.counting_down ? sx32(r_pos_actual) - w_enc48
                                          : sx32(r_pos_actual) + w_enc48;
        w_enc_ext  = {r_item.encoder_count[15], r_item.encoder_count};
        w_enc_mag  = w_enc_ext[16] ? 17'(-w_enc_ext) : 17'(w_enc_ext);
        w_out      = sat32(r_sum);
        w_neg      = -w_out;
    end

    assign o_stat.is_move = (r_item.command == CMD_MOVE);
    assign o_stat.div_hit = (r_div_cnt >= r_pos_div);
    assign o_result       = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_kp       <= RST_VEL_KP;
            r_vel_ki       <= RST_VEL_KI;
            r_vel_kd       <= RST_VEL_KD;
            r_pos_kp       <= RST_POS_KP;
            r_pos_ki       <= RST_POS_KI;
            r_pos_kd       <= RST_POS_KD;
            r_pos_div      <= RST_POS_DIV;
            r_pos_target   <= '0;
            r_pos_actual   <= '0;
            r_pos_err_last <= '0;
            r_pos_err_prev <= '0;
            r_pos_err_now  <= '0;
            r_pos_out      <= '0;
            r_vel_target   <= '0;
            r_vel_err_last <= '0;
            r_vel_err_prev <= '0;
            r_fwd_cmp      <= '0;
            r_rev_cmp      <= '0;
            r_move_flag    <= 1'b0;
            r_tick_cnt     <= '0;
            r_div_cnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VEL_KP:  r_vel_kp  <= i_cfg_data;
                    CFG_VEL_KI:  r_vel_ki  <= i_cfg_data;
                    CFG_VEL_KD:  r_vel_kd  <= i_cfg_data;
                    CFG_POS_KP:  r_pos_kp  <= i_cfg_data;
                    CFG_POS_KI:  r_pos_ki  <= i_cfg_data;
                    CFG_POS_KD:  r_pos_kd  <= i_cfg_data;
                    CFG_POS_DIV: r_pos_div <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                DP_MOVE: begin
                    // The new target is re-based on the error left by the last run.
                    r_pos_target <= sat32(sx32(r_item.move_target) + sx32(r_pos_err_now));
                    r_pos_actual <= '0;
                    r_move_flag  <= 1'b1;
                end
                DP_TICK: begin
                    r_pos_actual <= sat32(w_pos_step);
                    if (r_move_flag) begin
                        r_tick_cnt <= r_tick_cnt + 16'd1;
                    end
                    if (r_div_cnt >= r_pos_div) begin
                        r_div_cnt <= '0;
                    end else begin
                        r_div_cnt <= r_div_cnt + 8'd1;
                    end
                end
                DP_ERR: begin
                    if (!i_cmd.sel_vel) begin
                        r_pos_err_now <= sat32(sx32(w_target) - sx32(w_actual));
                    end
                end
                DP_UPD: begin
                    if (i_cmd.sel_vel) begin
                        r_vel_err_prev <= r_vel_err_last;
                        r_vel_err_last <= r_err;
                        if (w_out > 0) begin
                            r_rev_cmp <= '0;
                            r_fwd_cmp <= (w_out > CMP_LIMIT) ? CMP_LIMIT[15:0]
                                         : w_out[15:0] + w_enc_mag[15:0];
                        end else if (w_out < 0) begin
                            r_fwd_cmp <= '0;
                            r_rev_cmp <= (w_out < -CMP_LIMIT) ? CMP_LIMIT[15:0]
                                         : w_neg[15:0] + w_enc_mag[15:0];
                        end else if (r_pos_err_now == r_pos_out) begin
                            r_move_flag <= 1'b0;
                        end
                    end else begin
                        r_pos_err_prev <= r_pos_err_last;
                        r_pos_err_last <= r_err;
                        r_pos_out      <= w_out;
                        r_vel_target   <= w_out;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: r_item <= i_item;
            DP_ERR:  r_err  <= sat32(sx32(w_target) - sx32(w_actual));
            DP_DIFF: begin
                r_d1 <= sat32(sx32(r_err) - sx32(w_e1));
                r_d2 <= sat32(sx32(r_err) - (sx32(w_e1) <<< 1) + sx32(w_e2));
            end
            DP_MUL_P: r_prod <= w_prod;
            DP_MUL_I: begin
                r_sum  <= sx32(sat32(r_prod));
                r_prod <= w_prod;
            end
            DP_MUL_D: begin
                r_sum  <= r_sum + sx32(sat32(r_prod));
                r_prod <= w_prod;
            end
            DP_ACC: r_sum <= r_sum + sx32(sat32(r_prod));
            DP_OUT: begin
                r_result.forward_compare <= r_fwd_cmp;
                r_result.reverse_compare <= r_rev_cmp;
                r_result.moving          <= r_move_flag;
                r_result.move_ticks      <= r_tick_cnt;
                r_result.position        <= r_pos_actual;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/cpvpid_ctrl.sv
`default_nettype none

module cpvpid_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    input  wire cpvpid_pkg::t_dp_stat  i_stat,
    output cpvpid_pkg::t_dp_cmd        o_cmd
);
    import cpvpid_pkg::*;

    t_state r_state, n_state;
    logic   r_sel_vel, n_sel_vel;
    logic   r_o_valid, n_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel_vel <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel_vel <= n_sel_vel;
            r_o_valid <= n_o_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_sel_vel     = r_sel_vel;
        o_cmd.op      = DP_NONE;
        o_cmd.sel_vel = r_sel_vel;
        o_ready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_PRE;
                end
            end
            S_PRE: begin
                // A move always runs the position loop; a tick skips it until the
                // divider count comes around.
                if (i_stat.is_move) begin
                    o_cmd.op  = DP_MOVE;
                    n_sel_vel = 1'b0;
                end else begin
                    o_cmd.op  = DP_TICK;
                    n_sel_vel = !i_stat.div_hit;
                end
                n_state = S_ERR;
            end
            S_ERR: begin
                o_cmd.op = DP_ERR;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = DP_DIFF;
                n_state  = S_MUL_P;
            end
            S_MUL_P: begin
                o_cmd.op = DP_MUL_P;
                n_state  = S_MUL_I;
            end
            S_MUL_I: begin
                o_cmd.op = DP_MUL_I;
                n_state  = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.op = DP_MUL_D;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = DP_ACC;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = DP_UPD;
                if (!r_sel_vel && !i_stat.is_move) begin
                    n_sel_vel = 1'b1;
                    n_state   = S_ERR;
                end else begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!r_o_valid || i_ready) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.op == DP_OUT) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    assign o_valid = r_o_valid;

endmodule

`default_nettype wire

### rtl/core/cpvpid_checker.sv
`default_nettype none

`include "cascaded_position_velocity_pid_defines.svh"

module cpvpid_checker (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic                   o_ready,
    input  wire logic                   o_valid,
    input  wire logic                   i_ready,
    input  wire cpvpid_pkg::t_out_item  o_result
);
    import cpvpid_pkg::*;

    // A held result must not change under a stalled receiver.
    `CPV_ASSERT(a_result_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_result))

    `CPV_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_valid)

    // Each transaction keeps the block busy, so o_ready drops once one is accepted.
    `CPV_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)

    // The loop drives at most one bridge side at a time.
    `CPV_ASSERT(a_one_side, i_clk, i_rst_n, o_valid |-> (o_result.forward_compare == 16'd0 || o_result.reverse_compare == 16'd0))

    `CPV_ASSERT(a_cmp_range, i_clk, i_rst_n, o_valid |-> o_result.forward_compare <= 16'd33768 && o_result.reverse_compare <= 16'd33768)

endmodule

bind cascaded_position_velocity_pid cpvpid_checker u_checker (.*);

`default_nettype wire
